// ----- rtl/rar_pkg.sv -----
// Shared types, codes and constants for the rational arithmetic reducer.
package rar_pkg;

    localparam int OPERAND_WIDTH_DEF = 32;
    localparam int FIELD_W           = 32;
    localparam int RES_W             = 64;
    localparam int CNT_W             = $clog2(RES_W);

    localparam logic [2:0] ACT_ADD  = 3'd0;
    localparam logic [2:0] ACT_SUB  = 3'd1;
    localparam logic [2:0] ACT_MUL  = 3'd2;
    localparam logic [2:0] ACT_DIV  = 3'd3;
    localparam logic [2:0] ACT_PASS = 3'd4;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_A,
        ST_MUL_B,
        ST_MUL_C,
        ST_FORM,
        ST_CHECK,
        ST_STRIP,
        ST_GCD,
        ST_DIV_N,
        ST_DIV_D,
        ST_SIGN
    } state_t;

    typedef struct packed {
        logic [2:0]                action;
        logic signed [FIELD_W-1:0] a_num;
        logic signed [FIELD_W-1:0] a_den;
        logic signed [FIELD_W-1:0] b_num;
        logic signed [FIELD_W-1:0] b_den;
        logic                      simplify;
    } item_t;

    typedef struct packed {
        logic signed [RES_W-1:0] res_num;
        logic signed [RES_W-1:0] res_den;
        logic                    zero_den_error;
    } result_t;

endpackage

// ----- rtl/rar_mul.sv -----
// Registered signed operand multiplier shared by all cross products.
module rar_mul #(
    parameter int OPERAND_WIDTH = rar_pkg::OPERAND_WIDTH_DEF
) (
    input  logic                              clk,
    input  logic signed [OPERAND_WIDTH-1:0]   a,
    input  logic signed [OPERAND_WIDTH-1:0]   b,
    output logic signed [2*OPERAND_WIDTH-1:0] p
);

    logic signed [2*OPERAND_WIDTH-1:0] p_reg;

    always_ff @(posedge clk)
    begin
        p_reg <= a * b;
    end

    assign p = p_reg;

endmodule

// ----- rtl/rational_arithmetic_reduce.sv -----
// Top level: rational add/sub/mul/div/pass with optional reduction to lowest terms.
//
// A beat is taken when start is high and busy is low; busy then stays high until the
// result has been formed. The result shows on result for exactly one cycle with done high
// and cannot be stalled. Without simplify an item takes three products through one
// registered multiplier, then one combine step. With simplify the sequencer then drives a
// single 65-bit subtractor: it strips common factors of two, then runs a binary gcd and
// two restoring divisions. A zero term under simplify finishes at the check step.
module rational_arithmetic_reduce #(
    parameter int OPERAND_WIDTH = rar_pkg::OPERAND_WIDTH_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  rar_pkg::item_t   item,
    output logic             busy,
    output logic             done,
    output rar_pkg::result_t result
);

    localparam int RW = rar_pkg::RES_W;
    localparam int CW = rar_pkg::CNT_W;

    rar_pkg::state_t  state_reg, state_next;
    rar_pkg::item_t   item_reg, item_next;
    rar_pkg::result_t res_reg, res_next;
    logic             done_reg, done_next;

    logic [RW-1:0] pa_reg, pa_next;
    logic [RW-1:0] pb_reg, pb_next;
    logic [RW-1:0] rn_reg, rn_next;
    logic [RW-1:0] rd_reg, rd_next;
    logic [RW-1:0] x_reg, x_next;
    logic [RW-1:0] y_reg, y_next;
    logic [RW-1:0] qn_reg, qn_next;
    logic [RW-1:0] qd_reg, qd_next;
    logic [RW-1:0] quot_reg, quot_next;
    logic [RW-1:0] rem_reg, rem_next;
    logic [CW-1:0] cnt_reg, cnt_next;

    logic signed [OPERAND_WIDTH-1:0]   an_w, ad_w, bn_w, bd_w;
    logic signed [OPERAND_WIDTH-1:0]   mul_a, mul_b;
    logic signed [2*OPERAND_WIDTH-1:0] mul_p;
    logic [RW-1:0] prod;
    logic [RW-1:0] an_ext, ad_ext;
    logic [RW-1:0] mn, md;
    logic [RW-1:0] rs;
    logic [RW:0]   sub_a, sub_b, diff;
    logic          qbit;
    logic          div_last;

    assign an_w   = $signed(item_reg.a_num[OPERAND_WIDTH-1:0]);
    assign ad_w   = $signed(item_reg.a_den[OPERAND_WIDTH-1:0]);
    assign bn_w   = $signed(item_reg.b_num[OPERAND_WIDTH-1:0]);
    assign bd_w   = $signed(item_reg.b_den[OPERAND_WIDTH-1:0]);
    assign an_ext = RW'(an_w);
    assign ad_ext = RW'(ad_w);
    assign prod   = RW'(mul_p);

    rar_mul #(
        .OPERAND_WIDTH(OPERAND_WIDTH)
    ) u_mul (
        .clk(clk),
        .a  (mul_a),
        .b  (mul_b),
        .p  (mul_p)
    );

    assign mn       = rn_reg[RW-1] ? -rn_reg : rn_reg;
    assign md       = rd_reg[RW-1] ? -rd_reg : rd_reg;
    assign rs       = {rem_reg[RW-2:0], quot_reg[RW-1]};
    assign diff     = sub_a - sub_b;
    assign qbit     = ~diff[RW];
    assign div_last = (cnt_reg == CW'(RW - 1));

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            rar_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = rar_pkg::ST_MUL_A;
                end
            end
            rar_pkg::ST_MUL_A: state_next = rar_pkg::ST_MUL_B;
            rar_pkg::ST_MUL_B: state_next = rar_pkg::ST_MUL_C;
            rar_pkg::ST_MUL_C: state_next = rar_pkg::ST_FORM;
            rar_pkg::ST_FORM:
            begin
                state_next = item_reg.simplify ? rar_pkg::ST_CHECK : rar_pkg::ST_IDLE;
            end
            rar_pkg::ST_CHECK:
            begin
                if (md == '0 || mn == '0)
                begin
                    state_next = rar_pkg::ST_IDLE;
                end
                else
                begin
                    state_next = rar_pkg::ST_STRIP;
                end
            end
            rar_pkg::ST_STRIP:
            begin
                if (x_reg[0] | y_reg[0])
                begin
                    state_next = rar_pkg::ST_GCD;
                end
            end
            rar_pkg::ST_GCD:
            begin
                if (diff[RW-1:0] == '0)
                begin
                    state_next = rar_pkg::ST_DIV_N;
                end
            end
            rar_pkg::ST_DIV_N:
            begin
                if (div_last)
                begin
                    state_next = rar_pkg::ST_DIV_D;
                end
            end
            rar_pkg::ST_DIV_D:
            begin
                if (div_last)
                begin
                    state_next = rar_pkg::ST_SIGN;
                end
            end
            rar_pkg::ST_SIGN: state_next = rar_pkg::ST_IDLE;
            default:          state_next = rar_pkg::ST_IDLE;
        endcase
    end

    // state outputs: handshake and shared unit operand select
    always_comb
    begin
        busy  = 1'b1;
        mul_a = an_w;
        mul_b = bd_w;
        sub_a = {1'b0, x_reg};
        sub_b = {1'b0, y_reg};
        unique case (state_reg)
            rar_pkg::ST_IDLE:
            begin
                busy = 1'b0;
            end
            rar_pkg::ST_MUL_A:
            begin
                mul_a = an_w;
                mul_b = (item_reg.action == rar_pkg::ACT_MUL) ? bn_w : bd_w;
            end
            rar_pkg::ST_MUL_B:
            begin
                mul_a = ad_w;
                mul_b = bn_w;
            end
            rar_pkg::ST_MUL_C:
            begin
                mul_a = ad_w;
                mul_b = (item_reg.action == rar_pkg::ACT_DIV) ? bn_w : bd_w;
            end
            rar_pkg::ST_DIV_N, rar_pkg::ST_DIV_D:
            begin
                sub_a = {1'b0, rs};
                sub_b = {1'b0, x_reg};
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

    // datapath
    always_comb
    begin
        item_next = item_reg;
        res_next  = res_reg;
        done_next = 1'b0;
        pa_next   = pa_reg;
        pb_next   = pb_reg;
        rn_next   = rn_reg;
        rd_next   = rd_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        qn_next   = qn_reg;
        qd_next   = qd_reg;
        quot_next = quot_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        case (state_reg)
            rar_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    item_next = item;
                end
            end
            rar_pkg::ST_MUL_B:
            begin
                pa_next = prod;
            end
            rar_pkg::ST_MUL_C:
            begin
                pb_next = prod;
            end
            rar_pkg::ST_FORM:
            begin
                case (item_reg.action) inside
                    rar_pkg::ACT_ADD:
                    begin
                        rn_next = pa_reg + pb_reg;
                        rd_next = prod;
                    end
                    rar_pkg::ACT_SUB:
                    begin
                        rn_next = pa_reg - pb_reg;
                        rd_next = prod;
                    end
                    rar_pkg::ACT_MUL, rar_pkg::ACT_DIV:
                    begin
                        rn_next = pa_reg;
                        rd_next = prod;
                    end
                    default:
                    begin
                        rn_next = an_ext;
                        rd_next = ad_ext;
                    end
                endcase
                if (!item_reg.simplify)
                begin
                    res_next.res_num        = rn_next;
                    res_next.res_den        = rd_next;
                    res_next.zero_den_error = 1'b0;
                    done_next               = 1'b1;
                end
            end
            rar_pkg::ST_CHECK:
            begin
                x_next = mn;
                y_next = md;
                if (md == '0)
                begin
                    res_next.res_num        = '0;
                    res_next.res_den        = '0;
                    res_next.zero_den_error = 1'b1;
                    done_next               = 1'b1;
                end
                else if (mn == '0)
                begin
                    res_next.res_num        = '0;
                    res_next.res_den        = RW'(1);
                    res_next.zero_den_error = 1'b0;
                    done_next               = 1'b1;
                end
            end
            rar_pkg::ST_STRIP:
            begin
                // common powers of two come off both terms
                if (x_reg[0] | y_reg[0])
                begin
                    qn_next = x_reg;
                    qd_next = y_reg;
                end
                else
                begin
                    x_next = x_reg >> 1;
                    y_next = y_reg >> 1;
                end
            end
            rar_pkg::ST_GCD:
            begin
                if (diff[RW-1:0] == '0)
                begin
                    quot_next = qn_reg;
                    rem_next  = '0;
                    cnt_next  = '0;
                end
                else if (!x_reg[0])
                begin
                    x_next = x_reg >> 1;
                end
                else if (!y_reg[0])
                begin
                    y_next = y_reg >> 1;
                end
                else if (diff[RW])
                begin
                    x_next = y_reg;
                    y_next = x_reg;
                end
                else
                begin
                    x_next = {1'b0, diff[RW-1:1]};
                end
            end
            rar_pkg::ST_DIV_N, rar_pkg::ST_DIV_D:
            begin
                rem_next  = qbit ? diff[RW-1:0] : rs;
                quot_next = {quot_reg[RW-2:0], qbit};
                cnt_next  = cnt_reg + CW'(1);
                if (div_last)
                begin
                    if (state_reg == rar_pkg::ST_DIV_N)
                    begin
                        qn_next   = quot_next;
                        quot_next = qd_reg;
                        rem_next  = '0;
                    end
                    else
                    begin
                        qd_next = quot_next;
                    end
                end
            end
            rar_pkg::ST_SIGN:
            begin
                res_next.res_num        = rn_reg[RW-1] ? -qn_reg : qn_reg;
                res_next.res_den        = rd_reg[RW-1] ? -qd_reg : qd_reg;
                res_next.zero_den_error = 1'b0;
                done_next               = 1'b1;
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rar_pkg::ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        res_reg  <= res_next;
        pa_reg   <= pa_next;
        pb_reg   <= pb_next;
        rn_reg   <= rn_next;
        rd_reg   <= rd_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
        qn_reg   <= qn_next;
        qd_reg   <= qd_next;
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        cnt_reg  <= cnt_next;
    end

    assign done   = done_reg;
    assign result = res_reg;

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted beat did not raise busy");

    a_done_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result strobe without work in progress");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.zero_den_error |-> result.res_num == '0 && result.res_den == '0)
        else $error("zero denominator error with nonzero result");

    a_gcd_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == rar_pkg::ST_GCD |-> x_reg != '0 && y_reg != '0)
        else $error("gcd operand reached zero");

endmodule
